// ===== rtl/gda_pkg.sv =====
// Package for the Gregorian date arithmetic core: word types, constants, tables.
// No dependencies.
`default_nettype none
package gda_pkg;
  localparam int unsigned OffsetBitsDef = 16;
  localparam int unsigned MaxEpoch      = 3652059;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnset   = 2'd1;
  localparam logic [1:0] StBad     = 2'd2;
  localparam logic [1:0] StRange   = 2'd3;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } gda_date_t;

  typedef struct packed {
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic [21:0] epoch_days;
    logic [8:0]  day_of_year;
    logic [8:0]  days_to_year_end;
    logic [2:0]  weekday;
    logic [1:0]  status;
  } gda_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_YEARS, S_ORD, S_SHIFT, S_WALK_Y, S_WALK_M, S_WKDAY, S_DONE
  } gda_state_e;

  // century test via y/25 by reciprocal multiply, exact for y < 16384
  function automatic logic is_leap(input logic [13:0] y);
    logic [28:0] prod;
    logic [9:0]  q25;
    logic        by25;
    prod = 29'(y) * 29'd20972;
    q25  = prod[28:19];
    by25 = (({4'b0000, q25} * 14'd25) == y);
    return (y[1:0] == 2'b00) && (!by25 || (y[3:0] == 4'b0000));
  endfunction

  // 8 = 1 mod 7: fold octal digits, then one compare/subtract
  function automatic logic [2:0] mod7(input logic [8:0] v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(v[8:6]) + 5'(v[5:3]) + 5'(v[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

  function automatic logic [8:0] cum_days(input logic [3:0] m);
    unique case (m)
      4'd1: return 9'd0;    4'd2: return 9'd31;   4'd3: return 9'd59;
      4'd4: return 9'd90;   4'd5: return 9'd120;  4'd6: return 9'd151;
      4'd7: return 9'd181;  4'd8: return 9'd212;  4'd9: return 9'd243;
      4'd10: return 9'd273; 4'd11: return 9'd304; 4'd12: return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    unique case (m)
      4'd2: return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/gregorian_date_arithmetic_core.sv =====
// Top level of the Gregorian date arithmetic core: sequencer and shared adder.
// Depends on gda_pkg.
//
//  channel | dir | handshake            | word
//  in      | in  | in_valid_i/in_stall_o | gda_date_t + offset_days_i
//  out     | out | out_valid_o/out_stall_i | gda_out_t
//
// A word first counts years up to Y, the input year, then walks the shifted
// year N and month M. Unset or malformed dates go from S_CHECK straight to
// S_DONE, a shift out of range from S_SHIFT. The per-year loops through the shared
// add/compare unit set the duration.
// Reset clears the sequencer and the output valid. A stalled output holds
// the result; the next word is computed meanwhile and waits in S_DONE.
`default_nettype none
module gregorian_date_arithmetic_core
  import gda_pkg::*;
#(
  parameter int unsigned OFFSET_BITS = OffsetBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire gda_date_t              in_date_i,
  input  wire logic [OFFSET_BITS-1:0] offset_days_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output gda_out_t                    out_word_o
);
  localparam int unsigned TW = ((OFFSET_BITS > 22) ? OFFSET_BITS : 22) + 2;

  gda_state_e  state_q, state_d;
  gda_date_t   din_q;
  logic signed [TW-1:0] off_q;
  logic [13:0] yc_q, yc_d;
  logic [21:0] acc_q, acc_d;
  logic signed [TW-1:0] t_q, t_d;
  logic [3:0]  mc_q, mc_d;
  logic [2:0]  wk_q, wk_d;
  logic [1:0]  st_q, st_d;
  logic [8:0]  ord_q, ord_d;
  logic        out_valid_q;
  gda_out_t    out_q;
  logic        done_fire;

  logic        leap_in, leap_yc;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  assign leap_in = is_leap(din_q.year);
  assign leap_yc = is_leap(yc_q);
  assign ylen    = leap_yc ? 9'd366 : 9'd365;
  assign mlen    = month_len(mc_q, leap_yc);
  assign done_fire = (state_q == S_DONE) && !(out_valid_q && out_stall_i);

  // weekday: count year-start weekday forward; 0001-01-01 is Monday (2)
  logic [2:0] wk_step;
  always_comb begin
    wk_step = leap_yc ? 3'd2 : 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && !in_stall_o) begin
      din_q <= in_date_i;
      off_q <= TW'($signed(offset_days_i));
    end
    yc_q  <= yc_d;
    acc_q <= acc_d;
    t_q   <= t_d;
    mc_q  <= mc_d;
    wk_q  <= wk_d;
    st_q  <= st_d;
    ord_q <= ord_d;
    if (done_fire) begin
      out_q.epoch_days       <= (st_q == StUnset || st_q == StBad) ? '0 : acc_q;
      out_q.day_of_year      <= (st_q == StUnset || st_q == StBad) ? '0 : ord_q;
      out_q.days_to_year_end <= (st_q == StUnset || st_q == StBad) ? '0 :
                                ((leap_in ? 9'd366 : 9'd365) - ord_q);
      out_q.weekday          <= (st_q == StUnset || st_q == StBad) ? '0 : wk_q;
      out_q.status           <= st_q;
      out_q.new_day          <= (st_q == StOk) ? 5'(t_q + 1) : '0;
      out_q.new_month        <= (st_q == StOk) ? mc_q : '0;
      out_q.new_year         <= (st_q == StOk) ? yc_q : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i && !in_stall_o) state_d = S_CHECK;
      S_CHECK:  state_d = (din_q == '0 || st_d == StBad) ? S_DONE : S_YEARS;
      S_YEARS:  if (yc_q == din_q.year) state_d = S_ORD;
      S_ORD:    state_d = S_SHIFT;
      S_SHIFT:  state_d = (st_d == StRange) ? S_DONE : S_WALK_Y;
      S_WALK_Y: if ($unsigned(t_q) < TW'(ylen)) state_d = S_WALK_M;
      S_WALK_M: if (mc_q == 4'd12 || $unsigned(t_q) < TW'(mlen)) state_d = S_DONE;
      S_DONE:   if (done_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    yc_d = yc_q; acc_d = acc_q; t_d = t_q; mc_d = mc_q;
    wk_d = wk_q; st_d = st_q; ord_d = ord_q;
    unique case (state_q)
      S_CHECK: begin
        yc_d = 14'd1; acc_d = '0; wk_d = 3'd2; st_d = StOk;
        if (din_q == '0) st_d = StUnset;
        else if (din_q.month < 4'd1 || din_q.month > 4'd12 || din_q.year < 14'd1 ||
                 din_q.year > 14'd9999 || din_q.day < 5'd1 ||
                 din_q.day > month_len(din_q.month, leap_in)) st_d = StBad;
      end
      S_YEARS: if (yc_q != din_q.year) begin
        acc_d = acc_q + 22'(ylen);
        yc_d  = yc_q + 14'd1;
        wk_d  = ({1'b0, wk_q} + {1'b0, wk_step} >= 4'd7) ?
                3'({1'b0, wk_q} + {1'b0, wk_step} - 4'd7) : (wk_q + wk_step);
      end
      S_ORD: begin
        ord_d = 9'(din_q.day) + cum_days(din_q.month) +
                9'((din_q.month > 4'd2 && leap_in) ? 1 : 0);
        acc_d = acc_q + 22'(ord_d);
        wk_d  = mod7(9'(wk_q) + ord_d + 9'd6);
      end
      S_SHIFT: begin
        t_d  = $signed({1'b0, acc_q}) + off_q - TW'(1);
        yc_d = 14'd1; mc_d = 4'd1;
        if (t_d < 0 || t_d > TW'(MaxEpoch - 1)) st_d = StRange;
      end
      S_WALK_Y: if ($unsigned(t_q) >= TW'(ylen)) begin
        t_d = t_q - TW'(ylen); yc_d = yc_q + 14'd1;
      end
      S_WALK_M: if (!(mc_q == 4'd12 || $unsigned(t_q) < TW'(mlen))) begin
        t_d = t_q - TW'(mlen); mc_d = mc_q + 4'd1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("result changed while stalled");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_valid_o) else $error("result lost");
`endif
endmodule
`default_nettype wire
